FILE: hdl/epg_pkg.sv
// Shared types, constants and codes for the eased path position generator.
// No dependencies; epg_if, epg_div and the top level import this package.
`timescale 1ns / 1ps

package epg_pkg;

	localparam int TABLE_DEPTH_DEF = 256;

	// divider operand widths, set by the widest numerator and denominator
	localparam int NUM_W = 50;
	localparam int DEN_W = 34;

	localparam int CFG_IDX_W  = 3;
	localparam int CFG_DATA_W = 32;

	localparam logic [CFG_IDX_W-1:0] CFG_RAMP_UP_END     = 3'd0;
	localparam logic [CFG_IDX_W-1:0] CFG_RAMP_DOWN_START = 3'd1;
	localparam logic [CFG_IDX_W-1:0] CFG_MOVING_TIME     = 3'd2;
	localparam logic [CFG_IDX_W-1:0] CFG_TOTAL_DISTANCE  = 3'd3;
	localparam logic [CFG_IDX_W-1:0] CFG_ENTRIES_IN_USE  = 3'd4;

	localparam logic [15:0] RST_RAMP_UP_END     = 16'd16384;
	localparam logic [15:0] RST_RAMP_DOWN_START = 16'd49152;
	localparam logic [31:0] RST_MOVING_TIME     = 32'd1000;

	localparam logic [1:0] ACT_TICK  = 2'd0;
	localparam logic [1:0] ACT_START = 2'd1;
	localparam logic [1:0] ACT_HOME  = 2'd2;
	localparam logic [1:0] ACT_LOAD  = 2'd3;

	localparam logic [16:0] ONE_Q16      = 17'd65536;
	localparam logic [24:0] INTERP_LIMIT = 25'd16777216;

	typedef struct packed {
		logic [1:0]         action;
		logic [15:0]        time_step;
		logic [7:0]         entry_index;
		logic [31:0]        entry_distance;
		logic signed [31:0] entry_x;
		logic signed [31:0] entry_y;
		logic signed [31:0] entry_z;
	} epg_req_t;

	typedef struct packed {
		logic signed [31:0] pos_x;
		logic signed [31:0] pos_y;
		logic signed [31:0] pos_z;
		logic               moving;
		logic [7:0]         segment_start;
	} epg_res_t;

	typedef struct packed {
		logic             start;
		logic [NUM_W-1:0] num;
		logic [DEN_W-1:0] den;
	} epg_div_req_t;

	typedef struct packed {
		logic             busy;
		logic             done;
		logic [NUM_W-1:0] quot;
	} epg_div_rsp_t;

	typedef enum logic [4:0] {
		ST_IDLE,
		ST_DISPATCH,
		ST_HOME_SET,
		ST_T_DIV,
		ST_T_WAIT,
		ST_EASE_MUL,
		ST_EASE_DIV,
		ST_S_WAIT,
		ST_DIST,
		ST_SRCH_RD,
		ST_SRCH_CMP,
		ST_SEG_RD_HI,
		ST_SEG_RD_LO,
		ST_SEG_CAP,
		ST_INTERP,
		ST_I_WAIT,
		ST_LERP_MUL,
		ST_LERP_ADD,
		ST_FIN
	} epg_state_t;

endpackage

FILE: hdl/epg_if.sv
// Valid/ready channel interfaces for request and result items.
// Depends on epg_pkg for the payload structs.
`timescale 1ns / 1ps

interface epg_req_if;
	import epg_pkg::*;
	logic     valid;
	logic     ready;
	epg_req_t data;
	modport source(output valid, output data, input ready);
	modport sink(input valid, input data, output ready);
endinterface

interface epg_res_if;
	import epg_pkg::*;
	logic     valid;
	logic     ready;
	epg_res_t data;
	modport source(output valid, output data, input ready);
	modport sink(input valid, input data, output ready);
endinterface

FILE: hdl/eased_path_position_generator.sv
// Top level: eased path position generator (sequencer, datapath, table RAMs).
// Depends on epg_pkg, epg_if, epg_ram and epg_div.
`timescale 1ns / 1ps

// Channel  | Dir | Payload                                          | Handshake
// request  | in  | action, time_step, entry_index, entry_* fields   | valid/ready
// result   | out | pos_x, pos_y, pos_z, moving, segment_start       | valid/ready
// cfg      | in  | cfg_index, cfg_wdata                             | cfg_we only
//
// Every request item yields exactly one result item.
// Load, start and home items need no divider pass; a full tick makes up to
// three passes through the shared divider and steps a forward search over
// the table entries, read through the single read port of the table RAMs.
// Reset (arst_n) clears position, time, segment and travel; the tables are not
// cleared. A stalled result holds the finished item in the output register; the
// next request item is taken meanwhile and waits only at its own finish.

module eased_path_position_generator #(
	parameter int TABLE_DEPTH = epg_pkg::TABLE_DEPTH_DEF
) (
	input  logic                            clk,
	input  logic                            arst_n,
	input  logic                            cfg_we,
	input  logic [epg_pkg::CFG_IDX_W-1:0]   cfg_index,
	input  logic [epg_pkg::CFG_DATA_W-1:0]  cfg_wdata,
	epg_req_if.sink                         request,
	epg_res_if.source                       result
);
	import epg_pkg::*;

	localparam int AW = $clog2(TABLE_DEPTH);
	localparam int NW = $clog2(TABLE_DEPTH + 1);

	typedef enum logic [1:0] {RG_ACCEL, RG_CRUISE, RG_DECEL} ease_rg_t;

	// configuration
	logic [15:0] t1_q;
	logic [15:0] t2_q;
	logic [31:0] mt_q;
	logic [31:0] td_q;
	logic [8:0]  eiu_q;

	// architectural state
	epg_state_t         state_q, state_nx;
	logic [31:0]        elapsed_q;
	logic [AW-1:0]      ss_q;
	logic               travel_q;
	logic signed [31:0] cur_q [3];

	// per-item working registers
	epg_req_t           req_q;
	logic [16:0]        t_q;
	ease_rg_t           region_q;
	logic [34:0]        prod_a_q;
	logic [33:0]        prod_b_q;
	logic [33:0]        prod_c_q;
	logic [15:0]        s_q;
	logic [31:0]        dist_q;
	logic [AW-1:0]      idx_q;
	logic [AW-1:0]      lo_q;
	logic [31:0]        d1_q;
	logic [31:0]        d2_q;
	logic [95:0]        p1_q;
	logic [95:0]        p2_q;
	logic               neg_q;
	logic signed [25:0] interp_q;
	logic [1:0]         k_q;
	logic signed [58:0] prod_q;
	logic signed [31:0] base_q;

	// output register
	epg_res_t res_q;
	logic     res_valid_q;

	// memories and divider
	logic          tbl_we;
	logic [AW-1:0] tbl_waddr;
	logic [AW-1:0] tbl_raddr;
	logic [31:0]   arc_rd;
	logic [95:0]   pts_rd;
	epg_div_req_t  div_req;
	epg_div_rsp_t  div_rsp;

	// combinational helpers
	logic [NW-1:0]      n_c;
	logic [NW-1:0]      idx_inc;
	ease_rg_t           region_c;
	logic [16:0]        d_c;
	logic [16:0]        w_c;
	logic [16:0]        u_c;
	logic [18:0]        coef_c;
	logic [17:0]        cruise_c;
	logic [33:0]        decel_c;
	logic [32:0]        sum_c;
	logic [32:0]        dd_c;
	logic [32:0]        diff_c;
	logic [31:0]        dd_mag;
	logic [31:0]        diff_mag;
	logic [24:0]        imag_c;
	logic [47:0]        dprod_c;
	logic signed [31:0] pa_c;
	logic signed [31:0] pb_c;
	logic signed [32:0] delta_c;
	logic signed [58:0] adj_c;
	logic signed [42:0] qd_c;
	logic signed [43:0] r_c;
	logic signed [31:0] rsat_c;
	logic               arc_less;
	logic               load_ok;

	// clamp the entry count to the table
	always_comb begin
		if (32'(eiu_q) > TABLE_DEPTH) begin
			n_c = NW'(TABLE_DEPTH);
		end else begin
			n_c = NW'(eiu_q);
		end
	end

	assign idx_inc  = NW'(idx_q) + 1'b1;
	assign load_ok  = 32'(req_q.entry_index) < TABLE_DEPTH;
	assign arc_less = arc_rd < dist_q;

	// ease profile terms
	always_comb begin
		d_c      = 17'(18'(ONE_Q16) - 18'(t1_q) + 18'(t2_q));
		w_c      = ONE_Q16 - 17'(t2_q);
		u_c      = t_q - 17'(t2_q);
		coef_c   = 19'({t2_q, 1'b0}) + 19'({u_c, 1'b0}) - 19'(t1_q);
		cruise_c = {t_q, 1'b0} - 18'(t1_q);
		decel_c  = 34'(prod_a_q) - prod_b_q;
		if (t_q <= 17'(t1_q)) begin
			region_c = RG_ACCEL;
		end else if (t_q <= 17'(t2_q)) begin
			region_c = RG_CRUISE;
		end else begin
			region_c = RG_DECEL;
		end
	end

	// segment interpolation terms
	always_comb begin
		sum_c    = {1'b0, elapsed_q} + 33'(req_q.time_step);
		dprod_c  = td_q * s_q;
		dd_c     = {1'b0, dist_q} - {1'b0, d1_q};
		diff_c   = {1'b0, d2_q} - {1'b0, d1_q};
		dd_mag   = dd_c[32] ? 32'(-dd_c) : dd_c[31:0];
		diff_mag = diff_c[32] ? 32'(-diff_c) : diff_c[31:0];
		if (div_rsp.quot > NUM_W'(INTERP_LIMIT)) begin
			imag_c = INTERP_LIMIT;
		end else begin
			imag_c = div_rsp.quot[24:0];
		end
	end

	// coordinate step: round the scaled delta toward zero, then saturate
	always_comb begin
		pa_c    = p1_q[k_q*32 +: 32];
		pb_c    = p2_q[k_q*32 +: 32];
		delta_c = 33'(pb_c) - 33'(pa_c);
		adj_c   = prod_q + (prod_q[58] ? 59'sd65535 : 59'sd0);
		qd_c    = 43'(adj_c >>> 16);
		r_c     = 44'(base_q) + 44'(qd_c);
		if (r_c > 44'sd2147483647) begin
			rsat_c = 32'sh7FFFFFFF;
		end else if (r_c < -44'sd2147483648) begin
			rsat_c = 32'sh80000000;
		end else begin
			rsat_c = r_c[31:0];
		end
	end

	// next state
	always_comb begin
		state_nx = state_q;
		case (state_q)
			ST_IDLE: begin
				if (request.valid) state_nx = ST_DISPATCH;
			end
			ST_DISPATCH: begin
				case (req_q.action)
					ACT_TICK: state_nx = travel_q ? ST_T_DIV : ST_FIN;
					ACT_HOME: state_nx = (n_c != '0) ? ST_HOME_SET : ST_FIN;
					default:  state_nx = ST_FIN;
				endcase
			end
			ST_HOME_SET: state_nx = ST_FIN;
			ST_T_DIV:    state_nx = ST_T_WAIT;
			ST_T_WAIT: begin
				if (div_rsp.done) begin
					state_nx = (div_rsp.quot > NUM_W'(ONE_Q16)) ? ST_FIN : ST_EASE_MUL;
				end
			end
			ST_EASE_MUL: state_nx = ST_EASE_DIV;
			ST_EASE_DIV: begin
				if (region_q == RG_ACCEL && t1_q == '0) begin
					state_nx = (n_c == '0) ? ST_FIN : ST_DIST;
				end else begin
					state_nx = ST_S_WAIT;
				end
			end
			ST_S_WAIT: begin
				if (div_rsp.done) begin
					if (div_rsp.quot >= NUM_W'(ONE_Q16) || n_c == '0) begin
						state_nx = ST_FIN;
					end else begin
						state_nx = ST_DIST;
					end
				end
			end
			ST_DIST:    state_nx = ST_SRCH_RD;
			ST_SRCH_RD: state_nx = ST_SRCH_CMP;
			ST_SRCH_CMP: begin
				state_nx = (arc_less && idx_inc < n_c) ? ST_SRCH_RD : ST_SEG_RD_HI;
			end
			ST_SEG_RD_HI: state_nx = ST_SEG_RD_LO;
			ST_SEG_RD_LO: state_nx = ST_SEG_CAP;
			ST_SEG_CAP:   state_nx = ST_INTERP;
			ST_INTERP:    state_nx = (diff_c == '0) ? ST_LERP_MUL : ST_I_WAIT;
			ST_I_WAIT: begin
				if (div_rsp.done) state_nx = ST_LERP_MUL;
			end
			ST_LERP_MUL: state_nx = ST_LERP_ADD;
			ST_LERP_ADD: state_nx = (k_q == 2'd2) ? ST_FIN : ST_LERP_MUL;
			ST_FIN: begin
				if (!res_valid_q || result.ready) state_nx = ST_IDLE;
			end
			default: state_nx = ST_IDLE;
		endcase
	end

	// sequencer outputs: handshake, RAM ports, divider launches
	always_comb begin
		request.ready = (state_q == ST_IDLE);
		tbl_we        = (state_q == ST_DISPATCH) && (req_q.action == ACT_LOAD) && load_ok;
		tbl_waddr     = AW'(req_q.entry_index);
		tbl_raddr     = '0;
		div_req       = '0;
		case (state_q)
			ST_SRCH_RD, ST_SEG_RD_HI: tbl_raddr = idx_q;
			ST_SEG_RD_LO:             tbl_raddr = lo_q;
			ST_T_DIV: begin
				div_req.start = 1'b1;
				div_req.num   = NUM_W'({elapsed_q, 16'h0000});
				div_req.den   = DEN_W'((mt_q == '0) ? 32'd1 : mt_q);
			end
			ST_EASE_DIV: begin
				div_req.start = !(region_q == RG_ACCEL && t1_q == '0);
				case (region_q)
					RG_ACCEL: begin
						div_req.num = {prod_a_q[33:0], 16'h0000};
						div_req.den = prod_c_q;
					end
					RG_CRUISE: begin
						div_req.num = NUM_W'({cruise_c, 16'h0000});
						div_req.den = DEN_W'(d_c);
					end
					default: begin
						div_req.num = {decel_c, 16'h0000};
						div_req.den = prod_c_q;
					end
				endcase
			end
			ST_INTERP: begin
				div_req.start = (diff_c != '0);
				div_req.num   = NUM_W'({dd_mag, 16'h0000});
				div_req.den   = DEN_W'(diff_mag);
			end
			default: ;
		endcase
	end

	// control and architectural state
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q     <= ST_IDLE;
			t1_q        <= RST_RAMP_UP_END;
			t2_q        <= RST_RAMP_DOWN_START;
			mt_q        <= RST_MOVING_TIME;
			td_q        <= '0;
			eiu_q       <= '0;
			elapsed_q   <= '0;
			ss_q        <= '0;
			travel_q    <= 1'b0;
			cur_q[0]    <= '0;
			cur_q[1]    <= '0;
			cur_q[2]    <= '0;
			res_valid_q <= 1'b0;
		end else begin
			state_q <= state_nx;

			if (cfg_we) begin
				case (cfg_index)
					CFG_RAMP_UP_END:     t1_q  <= cfg_wdata[15:0];
					CFG_RAMP_DOWN_START: t2_q  <= cfg_wdata[15:0];
					CFG_MOVING_TIME:     mt_q  <= cfg_wdata;
					CFG_TOTAL_DISTANCE:  td_q  <= cfg_wdata;
					CFG_ENTRIES_IN_USE:  eiu_q <= cfg_wdata[8:0];
					default: ;
				endcase
			end

			case (state_q)
				ST_DISPATCH: begin
					case (req_q.action)
						ACT_TICK: begin
							// saturate elapsed time at all ones
							if (travel_q) begin
								elapsed_q <= sum_c[32] ? '1 : sum_c[31:0];
							end
						end
						ACT_START: travel_q <= 1'b1;
						ACT_HOME: begin
							elapsed_q <= '0;
							ss_q      <= '0;
							travel_q  <= 1'b0;
							if (n_c == '0) begin
								cur_q[0] <= '0;
								cur_q[1] <= '0;
								cur_q[2] <= '0;
							end
						end
						default: ;
					endcase
				end
				ST_HOME_SET: begin
					cur_q[0] <= pts_rd[31:0];
					cur_q[1] <= pts_rd[63:32];
					cur_q[2] <= pts_rd[95:64];
				end
				ST_T_WAIT: begin
					// time past the end: stop and hold position
					if (div_rsp.done && div_rsp.quot > NUM_W'(ONE_Q16)) travel_q <= 1'b0;
				end
				ST_S_WAIT: begin
					if (div_rsp.done && div_rsp.quot >= NUM_W'(ONE_Q16)) travel_q <= 1'b0;
				end
				ST_SEG_RD_HI: ss_q <= (idx_q == '0) ? '0 : idx_q - 1'b1;
				ST_LERP_ADD:  cur_q[k_q] <= rsat_c;
				default: ;
			endcase

			// drop a taken result, load the next at finish
			if (state_q == ST_FIN && (!res_valid_q || result.ready)) begin
				res_valid_q <= 1'b1;
			end else if (result.ready) begin
				res_valid_q <= 1'b0;
			end
		end
	end

	// datapath payload registers
	always_ff @(posedge clk) begin
		case (state_q)
			ST_IDLE: begin
				if (request.valid) req_q <= request.data;
			end
			ST_T_WAIT: begin
				if (div_rsp.done) t_q <= div_rsp.quot[16:0];
			end
			ST_EASE_MUL: begin
				region_q <= region_c;
				if (region_c == RG_ACCEL) begin
					prod_a_q <= 35'(t_q * t_q);
					prod_c_q <= 34'(t1_q * d_c);
				end else begin
					prod_a_q <= 35'(coef_c[17:0] * w_c);
					prod_c_q <= 34'(w_c * d_c);
				end
				prod_b_q <= 34'(u_c * u_c);
			end
			ST_EASE_DIV: s_q <= '0;
			ST_S_WAIT: begin
				if (div_rsp.done) s_q <= div_rsp.quot[15:0];
			end
			ST_DIST: begin
				dist_q <= dprod_c[47:16];
				idx_q  <= (NW'(ss_q) >= n_c) ? AW'(n_c - 1'b1) : ss_q;
			end
			ST_SRCH_CMP: begin
				if (arc_less && idx_inc < n_c) idx_q <= idx_q + 1'b1;
			end
			ST_SEG_RD_HI: lo_q <= (idx_q == '0) ? '0 : idx_q - 1'b1;
			ST_SEG_RD_LO: begin
				d2_q <= arc_rd;
				p2_q <= pts_rd;
			end
			ST_SEG_CAP: begin
				d1_q <= arc_rd;
				p1_q <= pts_rd;
			end
			ST_INTERP: begin
				neg_q    <= dd_c[32] ^ diff_c[32];
				interp_q <= '0;
				k_q      <= '0;
			end
			ST_I_WAIT: begin
				if (div_rsp.done) interp_q <= neg_q ? -26'(imag_c) : 26'(imag_c);
			end
			ST_LERP_MUL: begin
				prod_q <= delta_c * interp_q;
				base_q <= pa_c;
			end
			ST_LERP_ADD: k_q <= k_q + 1'b1;
			ST_FIN: begin
				if (!res_valid_q || result.ready) begin
					res_q.pos_x         <= cur_q[0];
					res_q.pos_y         <= cur_q[1];
					res_q.pos_z         <= cur_q[2];
					res_q.moving        <= travel_q;
					res_q.segment_start <= 8'(ss_q);
				end
			end
			default: ;
		endcase
	end

	assign result.valid = res_valid_q;
	assign result.data  = res_q;

	epg_ram #(
		.WIDTH(32),
		.DEPTH(TABLE_DEPTH)
	) u_arc_ram (
		.clk  (clk),
		.we   (tbl_we),
		.waddr(tbl_waddr),
		.wdata(req_q.entry_distance),
		.raddr(tbl_raddr),
		.rdata(arc_rd)
	);

	epg_ram #(
		.WIDTH(96),
		.DEPTH(TABLE_DEPTH)
	) u_pts_ram (
		.clk  (clk),
		.we   (tbl_we),
		.waddr(tbl_waddr),
		.wdata({req_q.entry_z, req_q.entry_y, req_q.entry_x}),
		.raddr(tbl_raddr),
		.rdata(pts_rd)
	);

	epg_div u_div (
		.clk   (clk),
		.arst_n(arst_n),
		.req   (div_req),
		.rsp   (div_rsp)
	);

	// search never reads past the loaded entries
	a_srch_in_range: assert property (@(posedge clk) disable iff (!arst_n)
		(state_q == ST_SRCH_RD) |-> (NW'(idx_q) < n_c))
		else $error("table search index beyond loaded entries");

	// interpolation factor stays within its saturation bounds
	a_interp_bound: assert property (@(posedge clk) disable iff (!arst_n)
		(state_q == ST_LERP_MUL) |->
		(interp_q <= 26'sd16777216 && interp_q >= -26'sd16777216))
		else $error("interp factor out of range");

	// divider is only launched when idle
	a_div_free: assert property (@(posedge clk) disable iff (!arst_n)
		div_req.start |-> !div_rsp.busy)
		else $error("divider launched while busy");

	// ease reaching one stops travel
	a_stop_on_end: assert property (@(posedge clk) disable iff (!arst_n)
		(state_q == ST_S_WAIT && div_rsp.done && div_rsp.quot >= NUM_W'(ONE_Q16))
		|=> !travel_q)
		else $error("travel not stopped at end of ease");

endmodule

FILE: hdl/epg_ram.sv
// Generic single-write, single-read synchronous RAM with registered read.
// No dependencies.
`timescale 1ns / 1ps

module epg_ram #(
	parameter int WIDTH = 32,
	parameter int DEPTH = 256
) (
	input  logic                     clk,
	input  logic                     we,
	input  logic [$clog2(DEPTH)-1:0] waddr,
	input  logic [WIDTH-1:0]         wdata,
	input  logic [$clog2(DEPTH)-1:0] raddr,
	output logic [WIDTH-1:0]         rdata
);

	logic [WIDTH-1:0] mem [DEPTH];
	logic [WIDTH-1:0] rdata_q;

	always_ff @(posedge clk) begin
		if (we) begin
			mem[waddr] <= wdata;
		end
		rdata_q <= mem[raddr];
	end

	assign rdata = rdata_q;

endmodule

FILE: hdl/epg_div.sv
// Restoring unsigned divider, one quotient bit per cycle.
// Depends on epg_pkg for operand widths and request/response structs.
`timescale 1ns / 1ps

module epg_div (
	input  logic                  clk,
	input  logic                  arst_n,
	input  epg_pkg::epg_div_req_t req,
	output epg_pkg::epg_div_rsp_t rsp
);
	import epg_pkg::*;

	localparam int CNT_W = $clog2(NUM_W);

	logic             busy_q;
	logic             done_q;
	logic [CNT_W-1:0] cnt_q;
	logic [NUM_W-1:0] work_q;
	logic [DEN_W-1:0] rem_q;
	logic [DEN_W-1:0] den_q;
	logic [DEN_W:0]   rem_sh;
	logic [DEN_W:0]   rem_nx;
	logic             fits;

	always_comb begin
		rem_sh = {rem_q, work_q[NUM_W-1]};
		fits   = rem_sh >= {1'b0, den_q};
		rem_nx = fits ? (rem_sh - {1'b0, den_q}) : rem_sh;
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			busy_q <= 1'b0;
			done_q <= 1'b0;
			cnt_q  <= '0;
		end else begin
			done_q <= busy_q && (cnt_q == '0);
			if (req.start) begin
				busy_q <= 1'b1;
				cnt_q  <= CNT_W'(NUM_W - 1);
			end else if (busy_q) begin
				cnt_q <= cnt_q - 1'b1;
				if (cnt_q == '0) begin
					busy_q <= 1'b0;
				end
			end
		end
	end

	// quotient bits shift in behind the numerator bits
	always_ff @(posedge clk) begin
		if (req.start) begin
			work_q <= req.num;
			rem_q  <= '0;
			den_q  <= req.den;
		end else if (busy_q) begin
			work_q <= {work_q[NUM_W-2:0], fits};
			rem_q  <= rem_nx[DEN_W-1:0];
		end
	end

	assign rsp.busy = busy_q;
	assign rsp.done = done_q;
	assign rsp.quot = work_q;

endmodule
